// ----- sv/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescape unit
// Word formats, status codes, decoder modes and character helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_LF  = 8'h0a;
  localparam logic [7:0] CTL_CR  = 8'h0d;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [15:0] CP_ONE_MAX   = 16'h007f;
  localparam logic [15:0] CP_TWO_MAX   = 16'h07ff;
  localparam logic [15:0] CP_HSUR_MIN  = 16'hd800;
  localparam logic [15:0] CP_HSUR_MAX  = 16'hdbff;
  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TRUNC  = 3'd1,
    ST_BADHEX = 3'd2,
    ST_BADLOW = 3'd3,
    ST_BADESC = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_SUR_BS,
    MODE_SUR_U,
    MODE_SUR_HEX
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    status_t    status;
    logic       last;
  } jsu_out_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            byte_valid;
    logic            string_done;
    status_t         status;
  } jsu_burst_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- sv/jsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Accepts one string byte a cycle while the queue is not full, tracks escape state and emits a burst
// word of up to four result bytes into the queue.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  jsu_pkg::jsu_in_t    in_data,
  output logic                push,
  output jsu_pkg::jsu_burst_t burst
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] cp;
  logic [20:0] cp_sup;

  assign c      = in_data.data_byte;
  assign hv     = hex_val(c);
  assign cp     = {acc_r, hv[3:0]};
  assign cp_sup = {1'b0, hs_r, cp[9:0]} + CP_SUPP_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      hs_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      hs_r   <= hs_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    hs_nxt   = hs_r;
    push     = 1'b0;
    burst    = '0;
    burst.status = ST_OK;
    if (accept) begin
      if (in_data.end_of_input) begin
        push         = 1'b1;
        burst.status = ST_TRUNC;
        mode_nxt     = MODE_PLAIN;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        hs_nxt       = '0;
      end else begin
        unique case (mode_r)
          MODE_ESC: begin
            mode_nxt         = MODE_PLAIN;
            push             = 1'b1;
            burst.byte_valid = 1'b1;
            burst.bytes[0]   = c;
            unique case (c)
              CH_QUOTE, CH_BSL, CH_SLASH: burst.bytes[0] = c;
              CH_B: burst.bytes[0] = CTL_BS;
              CH_F: burst.bytes[0] = CTL_FF;
              CH_N: burst.bytes[0] = CTL_LF;
              CH_R: burst.bytes[0] = CTL_CR;
              CH_T: burst.bytes[0] = CTL_TAB;
              CH_U: begin
                push     = 1'b0;
                mode_nxt = MODE_HEX;
                acc_nxt  = '0;
                cnt_nxt  = '0;
              end
              default: begin
                burst.byte_valid = 1'b0;
                burst.bytes[0]   = '0;
                burst.status     = ST_BADESC;
                acc_nxt          = '0;
                cnt_nxt          = '0;
                hs_nxt           = '0;
              end
            endcase
          end
          MODE_HEX, MODE_SUR_HEX: begin
            if (!hv[4]) begin
              push         = 1'b1;
              burst.status = ST_BADHEX;
              mode_nxt     = MODE_PLAIN;
              acc_nxt      = '0;
              cnt_nxt      = '0;
              hs_nxt       = '0;
            end else if (cnt_r != 2'd3) begin
              acc_nxt = {acc_r[7:0], hv[3:0]};
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              acc_nxt          = '0;
              cnt_nxt          = '0;
              mode_nxt         = MODE_PLAIN;
              burst.byte_valid = 1'b1;
              push             = 1'b1;
              hs_nxt           = '0;
              priority if (mode_r == MODE_SUR_HEX) begin
                burst.bytes[0] = {5'b11110, cp_sup[20:18]};
                burst.bytes[1] = {2'b10, cp_sup[17:12]};
                burst.bytes[2] = {2'b10, cp_sup[11:6]};
                burst.bytes[3] = {2'b10, cp_sup[5:0]};
                burst.last_idx = 2'd3;
              end else if (cp >= CP_HSUR_MIN && cp <= CP_HSUR_MAX) begin
                push             = 1'b0;
                burst.byte_valid = 1'b0;
                hs_nxt           = cp[9:0];
                mode_nxt         = MODE_SUR_BS;
              end else if (cp <= CP_ONE_MAX) begin
                burst.bytes[0] = cp[7:0];
              end else if (cp <= CP_TWO_MAX) begin
                burst.bytes[0] = {3'b110, cp[10:6]};
                burst.bytes[1] = {2'b10, cp[5:0]};
                burst.last_idx = 2'd1;
              end else begin
                burst.bytes[0] = {4'b1110, cp[15:12]};
                burst.bytes[1] = {2'b10, cp[11:6]};
                burst.bytes[2] = {2'b10, cp[5:0]};
                burst.last_idx = 2'd2;
              end
            end
          end
          MODE_SUR_BS, MODE_SUR_U: begin
            if ((mode_r == MODE_SUR_BS && c != CH_BSL) ||
                (mode_r == MODE_SUR_U && c != CH_U)) begin
              push         = 1'b1;
              burst.status = ST_BADLOW;
              mode_nxt     = MODE_PLAIN;
              acc_nxt      = '0;
              cnt_nxt      = '0;
              hs_nxt       = '0;
            end else if (mode_r == MODE_SUR_BS) begin
              mode_nxt = MODE_SUR_U;
            end else begin
              mode_nxt = MODE_SUR_HEX;
              acc_nxt  = '0;
              cnt_nxt  = '0;
            end
          end
          default: begin
            mode_nxt = MODE_PLAIN;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            hs_nxt   = '0;
            priority if (c == CH_QUOTE) begin
              push              = 1'b1;
              burst.string_done = 1'b1;
            end else if (c == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end else begin
              push             = 1'b1;
              burst.byte_valid = 1'b1;
              burst.bytes[0]   = c;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- sv/jsu_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo: burst queue
// Short register queue between decoder and serializer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_burst_t wr_data,
  input  logic                pop,
  output jsu_pkg::jsu_burst_t rd_data,
  output logic                full,
  output logic                empty
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_burst_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- sv/jsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Walks the head burst one byte a cycle into the output register while that register is free or being popped.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jsu_pkg::jsu_burst_t head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output jsu_pkg::jsu_out_t   out_data
);
  import jsu_pkg::*;

  logic       ov_r;
  logic [1:0] idx_r;
  jsu_out_t   out_r;
  logic       load, is_last;

  assign load      = !q_empty && (!ov_r || out_pop);
  assign is_last   = (idx_r == head.last_idx);
  assign q_pop     = load && is_last;
  assign out_empty = !ov_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte    <= head.bytes[idx_r];
      out_r.byte_valid  <= head.byte_valid;
      out_r.string_done <= head.string_done;
      out_r.status      <= head.status;
      out_r.last        <= is_last;
    end
  end

endmodule

// ----- sv/json_string_unescape_utf8_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: JSON string body to UTF-8 decoder
// Path: each decoded result is written into the burst queue, then loaded into the output register.
// Throughput: one input byte per cycle while the burst queue is not full;
// results leave one per cycle while the receiver pops, so a burst of up to
// four UTF-8 bytes is absorbed by a QDEPTH-entry burst queue (default QUEUE_DEPTH).
// Reset: synchronous, active low; clears decoder state, queue and output.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit #(
  parameter int QDEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  jsu_pkg::jsu_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output jsu_pkg::jsu_out_t out_data
);
  import jsu_pkg::*;

  logic       accept;
  logic       f_push;
  jsu_burst_t f_burst;
  jsu_burst_t q_head;
  logic       q_full, q_empty, q_pop;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_data(in_data),
    .push   (f_push),
    .burst  (f_burst)
  );

  jsu_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_data(f_burst),
    .pop    (q_pop),
    .rd_data(q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.last) |=> !out_empty)
    else $error("burst broken before its last word");

  a_eoi_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.end_of_input) |-> (f_push && f_burst.status == ST_TRUNC))
    else $error("end of input did not queue a truncation word");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("burst queue popped while empty");

endmodule

// ----- bench/tb_json_string_unescape_utf8_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_unit: self-checking bench for the JSON unescaper
// Feeds string body bytes through the input queue port and decodes each one
// in a local scoreboard that tracks the escape state. Every popped word is
// compared field by field with the oldest predicted word. A short directed
// string comes first. Random escapes, surrogate pairs, quotes, truncations
// and broken sequences follow, under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_unit;
  import jsu_pkg::*;

  class unescape_scoreboard;
    mode_t       mode;
    logic [15:0] acc;
    logic [1:0]  ndig;
    logic [9:0]  hi_bits;
    jsu_out_t    decoded_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_escape();
    endfunction

    function void clear_escape();
      mode    = MODE_PLAIN;
      acc     = '0;
      ndig    = '0;
      hi_bits = '0;
    endfunction

    function void decode_byte(input jsu_in_t w);
      logic [7:0]  c;
      logic [7:0]  b[4];
      logic [15:0] nxt;
      logic [20:0] cp;
      int          d;
      int          n;
      logic        valid;
      logic        done;
      status_t     st;
      jsu_out_t    o;
      c     = w.data_byte;
      n     = 0;
      valid = 1'b1;
      done  = 1'b0;
      st    = ST_OK;
      b     = '{default: 8'h00};
      if (w.end_of_input) begin
        clear_escape();
        n     = 1;
        valid = 1'b0;
        st    = ST_TRUNC;
      end else begin
        case (mode)
          MODE_ESC: begin
            if (c == CH_U) begin
              mode = MODE_HEX;
              acc  = '0;
              ndig = '0;
            end else begin
              clear_escape();
              n    = 1;
              b[0] = c;
              case (c)
                CH_QUOTE, CH_BSL, CH_SLASH: ;
                CH_B: b[0] = CTL_BS;
                CH_F: b[0] = CTL_FF;
                CH_N: b[0] = CTL_LF;
                CH_R: b[0] = CTL_CR;
                CH_T: b[0] = CTL_TAB;
                default: begin
                  valid = 1'b0;
                  st    = ST_BADESC;
                end
              endcase
            end
          end
          MODE_HEX, MODE_SUR_HEX: begin
            d = -1;
            if (c >= "0" && c <= "9") d = c - 8'h30;
            else if (c >= "A" && c <= "F") d = c - 8'h37;
            else if (c >= "a" && c <= "f") d = c - 8'h57;
            if (d < 0) begin
              clear_escape();
              n     = 1;
              valid = 1'b0;
              st    = ST_BADHEX;
            end else if (ndig != 2'd3) begin
              acc  = {acc[11:0], d[3:0]};
              ndig = ndig + 2'd1;
            end else begin
              nxt = {acc[11:0], d[3:0]};
              if (mode == MODE_SUR_HEX) begin
                cp   = {1'b0, hi_bits, nxt[9:0]} + CP_SUPP_BASE;
                n    = 4;
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
                clear_escape();
              end else if (nxt >= CP_HSUR_MIN && nxt <= CP_HSUR_MAX) begin
                hi_bits = nxt[9:0];
                mode    = MODE_SUR_BS;
                acc     = '0;
                ndig    = '0;
              end else begin
                if (nxt <= CP_ONE_MAX) begin
                  n    = 1;
                  b[0] = nxt[7:0];
                end else if (nxt <= CP_TWO_MAX) begin
                  n    = 2;
                  b[0] = {3'b110, nxt[10:6]};
                  b[1] = {2'b10, nxt[5:0]};
                end else begin
                  n    = 3;
                  b[0] = {4'b1110, nxt[15:12]};
                  b[1] = {2'b10, nxt[11:6]};
                  b[2] = {2'b10, nxt[5:0]};
                end
                clear_escape();
              end
            end
          end
          MODE_SUR_BS: begin
            if (c == CH_BSL) begin
              mode = MODE_SUR_U;
            end else begin
              clear_escape();
              n     = 1;
              valid = 1'b0;
              st    = ST_BADLOW;
            end
          end
          MODE_SUR_U: begin
            if (c == CH_U) begin
              mode = MODE_SUR_HEX;
              acc  = '0;
              ndig = '0;
            end else begin
              clear_escape();
              n     = 1;
              valid = 1'b0;
              st    = ST_BADLOW;
            end
          end
          default: begin
            clear_escape();
            if (c == CH_QUOTE) begin
              n     = 1;
              valid = 1'b0;
              done  = 1'b1;
            end else if (c == CH_BSL) begin
              mode = MODE_ESC;
            end else begin
              n    = 1;
              b[0] = c;
            end
          end
        endcase
      end
      for (int i = 0; i < n; i++) begin
        o.out_byte    = valid ? b[i] : 8'h00;
        o.byte_valid  = valid;
        o.string_done = done;
        o.status      = st;
        o.last        = (i == n - 1);
        decoded_q.push_back(o);
      end
    endfunction

    function void compare_word(input jsu_out_t got);
      jsu_out_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: expected no word, got byte=%h valid=%b done=%b status=%0d last=%b",
                 $time, got.out_byte, got.byte_valid, got.string_done, got.status, got.last);
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.string_done !== want.string_done || got.status !== want.status ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: expected byte=%h valid=%b done=%b status=%0d last=%b", $time,
                   want.out_byte, want.byte_valid, want.string_done, want.status, want.last);
          $display("%0t:   actual byte=%h valid=%b done=%b status=%0d last=%b", $time,
                   got.out_byte, got.byte_valid, got.string_done, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_push;
  logic     in_full;
  jsu_in_t  in_data;
  logic     out_empty;
  logic     out_pop;
  jsu_out_t out_data;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int items_sent    = 0;
  int idle_plan[4]  = '{0, 88, 0, 36};
  int stall_plan[4] = '{0, 0, 88, 36};

  unescape_scoreboard sb = new();

  json_string_unescape_utf8_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic send_word(input logic [7:0] c, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push              = 1'b1;
    in_data.data_byte    = c;
    in_data.end_of_input = eoi;
    do @(posedge clk); while (in_full);
    sb.decode_byte(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_uescape(input logic [15:0] v);
    send_word(CH_BSL, 1'b0);
    send_word(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_word(hex_char(v[i*4 +: 4]), 1'b0);
  endtask

  task automatic send_random_sequence();
    logic [7:0]  c;
    logic [15:0] v;
    int          k;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 255);
        else do c = $urandom_range(0, 255); while (c == CH_QUOTE || c == CH_BSL);
        send_word(c, 1'b0);
      end
      5: begin
        case ($urandom_range(0, 7))
          0: c = CH_QUOTE;
          1: c = CH_BSL;
          2: c = CH_SLASH;
          3: c = CH_B;
          4: c = CH_F;
          5: c = CH_N;
          6: c = CH_R;
          default: c = CH_T;
        endcase
        send_word(CH_BSL, 1'b0);
        send_word(c, 1'b0);
      end
      6, 7: begin
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 16'h7f);
          1: v = $urandom_range(16'h80, 16'h7ff);
          2: v = $urandom_range(16'hdc00, 16'hdfff);
          default: do v = $urandom_range(16'h800, 16'hffff);
                   while (v >= CP_HSUR_MIN && v <= CP_HSUR_MAX);
        endcase
        send_uescape(v);
      end
      8, 9: begin
        send_uescape($urandom_range(CP_HSUR_MIN, CP_HSUR_MAX));
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 16'hffff);
        else v = $urandom_range(16'hdc00, 16'hdfff);
        send_uescape(v);
      end
      10: send_word(CH_QUOTE, 1'b0);
      11: send_word($urandom_range(0, 255), 1'b1);
      12: begin
        do c = $urandom_range(0, 255);
        while (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH || c == CH_B || c == CH_F ||
               c == CH_N || c == CH_R || c == CH_T || c == CH_U);
        send_word(CH_BSL, 1'b0);
        send_word(c, 1'b0);
      end
      13: begin
        if ($urandom_range(0, 2) == 0) send_uescape($urandom_range(CP_HSUR_MIN, CP_HSUR_MAX));
        send_word(CH_BSL, 1'b0);
        send_word(CH_U, 1'b0);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) send_word(hex_char($urandom_range(0, 15)), 1'b0);
        do c = $urandom_range(0, 255);
        while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
        send_word(c, 1'b0);
      end
      14: begin
        send_uescape($urandom_range(CP_HSUR_MIN, CP_HSUR_MAX));
        if ($urandom_range(0, 1)) begin
          do c = $urandom_range(0, 255); while (c == CH_BSL);
        end else begin
          send_word(CH_BSL, 1'b0);
          do c = $urandom_range(0, 255); while (c == CH_U);
        end
        send_word(c, 1'b0);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) send_uescape($urandom_range(CP_HSUR_MIN, CP_HSUR_MAX));
        send_word(CH_BSL, 1'b0);
        if ($urandom_range(0, 1)) begin
          send_word(CH_U, 1'b0);
          k = $urandom_range(0, 3);
          for (int i = 0; i < k; i++) send_word(hex_char($urandom_range(0, 15)), 1'b0);
        end
        send_word($urandom_range(0, 255), 1'b1);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (sb.decoded_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(0, 99) >= pop_stall_pct);
      @(posedge clk);
      if (out_pop && !out_empty) sb.compare_word(out_data);
    end
  end

  initial begin
    string script;
    int    base;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // plain extremes, simple escape, bad escape, surrogate pair, quote, truncation
    script = "\\n\\q\\uD83D\\ude00\"";
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    for (int i = 0; i < script.len(); i++) send_word(script[i], 1'b0);
    send_word(8'h5a, 1'b1);
    in_push = 1'b0;
    wait_drained();

    base = items_sent;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      pop_stall_pct = stall_plan[p];
      while (items_sent < base + 40 * (p + 1)) send_random_sequence();
    end
    in_push       = 1'b0;
    pop_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
